// File: hdl/cmvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmvm_pkg
// Shared sizes, codes and the partial-sum word passed along the cell chain.
// ----------------------------------------------------------------------------
package cmvm_pkg;

  localparam int MAX_DIM = 16;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = IDX_W + 1;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = 40;

  // input function codes
  localparam logic FN_MAT = 1'b0;
  localparam logic FN_VEC = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_SIZE   = 2'd2;

  // one row's partial sum travelling down the chain
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [IDX_W-1:0]        row;
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;
  } cmvm_tok_t;

  // matrix entry write; data broadcast to all cells, write enable only to the addressed column's cell
  typedef struct packed {
    logic                    we;
    logic [IDX_W-1:0]        row;
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
  } cmvm_mwr_t;

endpackage : cmvm_pkg
`default_nettype wire

// File: hdl/cmvm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmvm_cell
// One matrix column and one vector element; adds its complex product to the
// passing row sum over two stages (multiply, then accumulate).
// ----------------------------------------------------------------------------
module cmvm_cell
  import cmvm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire logic                    col_en,
  input  wire cmvm_mwr_t               mwr,
  input  wire logic                    vec_we,
  input  wire logic signed [VAL_W-1:0] vec_re,
  input  wire logic signed [VAL_W-1:0] vec_im,
  input  wire cmvm_tok_t               tok_in,
  output cmvm_tok_t                    tok_out
);

  logic signed [VAL_W-1:0]  col_re_r [MAX_DIM];
  logic signed [VAL_W-1:0]  col_im_r [MAX_DIM];
  logic [MAX_DIM-1:0]       col_vld_r;
  logic signed [VAL_W-1:0]  vre_r, vim_r;

  logic signed [VAL_W-1:0]  a_re, a_im;
  logic signed [PROD_W-1:0] rr_r, ii_r, ri_r, ir_r;
  logic signed [PROD_W-1:0] rr_nxt, ii_nxt, ri_nxt, ir_nxt;
  cmvm_tok_t                s1_tok_r, out_tok_r, out_tok_nxt;

  // column storage; entries never written read as zero
  always_ff @(posedge clk) begin
    if (mwr.we) begin
      col_re_r[mwr.row] <= mwr.re;
      col_im_r[mwr.row] <= mwr.im;
    end
    if (vec_we) begin
      vre_r <= vec_re;
      vim_r <= vec_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_vld_r <= '0;
    end else if (mwr.we) begin
      col_vld_r[mwr.row] <= 1'b1;
    end
  end

  always_comb begin
    a_re = col_vld_r[tok_in.row] ? col_re_r[tok_in.row] : '0;
    a_im = col_vld_r[tok_in.row] ? col_im_r[tok_in.row] : '0;
    if (col_en) begin
      rr_nxt = a_re * vre_r;
      ii_nxt = a_im * vim_r;
      ri_nxt = a_re * vim_r;
      ir_nxt = a_im * vre_r;
    end else begin
      rr_nxt = '0;
      ii_nxt = '0;
      ri_nxt = '0;
      ir_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rr_r <= rr_nxt;
      ii_r <= ii_nxt;
      ri_r <= ri_nxt;
      ir_r <= ir_nxt;
    end
  end

  always_comb begin
    out_tok_nxt        = s1_tok_r;
    out_tok_nxt.acc_re = s1_tok_r.acc_re + ACC_W'(rr_r) - ACC_W'(ii_r);
    out_tok_nxt.acc_im = s1_tok_r.acc_im + ACC_W'(ri_r) + ACC_W'(ir_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tok_r  <= '0;
      out_tok_r <= '0;
    end else if (adv) begin
      s1_tok_r  <= tok_in;
      out_tok_r <= out_tok_nxt;
    end
  end

  assign tok_out = out_tok_r;

endmodule : cmvm_cell
`default_nettype wire

// File: hdl/complex_matrix_vector_multiply.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_matrix_vector_multiply
// Q1.15 complex matrix times vector; a chain of column cells builds each
// row's exact 40-bit dot product.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall  func, row, col, value_re/im, last
// out_      output     out_valid/out_stall status, out_re, out_im, last_out
// cfg_      input      cfg_we             size_in_use
//
// matrix writes and vector elements are taken whenever in_valid is high and in_stall is low.
// after the last element, row sums enter the chain one per cycle while out_stall
// does not freeze it; they pass through all MAX_DIM cells, including disabled
// ones, and leave in row order.
// no input word is taken while rows are in the chain; out_stall freezes it.
// synchronous reset clears the matrix to zero and sets the size to 16.
// ----------------------------------------------------------------------------
module complex_matrix_vector_multiply
  import cmvm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CNT_W-1:0]        cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_func,
  input  wire logic [IDX_W-1:0]        in_row,
  input  wire logic [IDX_W-1:0]        in_col,
  input  wire logic signed [VAL_W-1:0] in_value_re,
  input  wire logic signed [VAL_W-1:0] in_value_im,
  input  wire logic                    in_last,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [1:0]                   out_status,
  output logic signed [ACC_W-1:0]      out_re,
  output logic signed [ACC_W-1:0]      out_im,
  output logic                         out_last_out
);

  logic [CNT_W-1:0] size_r;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] vcnt_r, vcnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             busy_r, busy_nxt;
  logic             feed_r, feed_nxt;
  logic [IDX_W-1:0] frow_r, frow_nxt;
  logic             feed_last;

  logic             adv, acc_in, oob, mismatch, err_load, start;
  logic [1:0]       err_code;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_status_r;
  logic signed [ACC_W-1:0] out_re_r, out_im_r;
  logic                    out_last_r;

  cmvm_mwr_t    mwr   [MAX_DIM];
  logic [MAX_DIM-1:0] vec_we;
  cmvm_tok_t    chain [MAX_DIM+1];
  cmvm_tok_t    tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= CNT_W'(MAX_DIM);
    end else if (cfg_we) begin
      size_r <= cfg_data;
    end
  end

  assign n_eff = (size_r == '0) ? CNT_W'(1) :
                 (size_r > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : size_r;

  // chain moves only when the output register can take its tail
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = busy_r || !adv;
  assign acc_in   = in_valid && !in_stall;

  assign oob      = ({1'b0, in_row} >= n_eff) || ({1'b0, in_col} >= n_eff);
  assign mismatch = ovf_r || (vcnt_r == CNT_W'(MAX_DIM)) ||
                    ((vcnt_r + CNT_W'(1)) != n_eff);

  always_comb begin
    err_load = 1'b0;
    err_code = ST_OK;
    start    = 1'b0;
    if (acc_in) begin
      if (in_func == FN_MAT) begin
        err_load = oob;
        err_code = ST_BOUNDS;
      end else if (in_last) begin
        err_load = mismatch;
        err_code = ST_SIZE;
        start    = !mismatch;
      end
    end
  end

  always_comb begin
    vcnt_nxt = vcnt_r;
    ovf_nxt  = ovf_r;
    if (acc_in && in_func == FN_VEC) begin
      if (in_last) begin
        vcnt_nxt = '0;
        ovf_nxt  = 1'b0;
      end else if (vcnt_r < CNT_W'(MAX_DIM)) begin
        vcnt_nxt = vcnt_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  assign feed_last = (frow_r == IDX_W'(n_eff - CNT_W'(1)));

  always_comb begin
    feed_nxt = feed_r;
    frow_nxt = frow_r;
    busy_nxt = busy_r;
    if (start) begin
      feed_nxt = 1'b1;
      frow_nxt = '0;
      busy_nxt = 1'b1;
    end else begin
      if (adv && feed_r) begin
        if (feed_last) begin
          feed_nxt = 1'b0;
        end else begin
          frow_nxt = frow_r + IDX_W'(1);
        end
      end
      if (adv && tail.valid && tail.last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= '0;
      ovf_r  <= 1'b0;
      busy_r <= 1'b0;
      feed_r <= 1'b0;
      frow_r <= '0;
    end else begin
      vcnt_r <= vcnt_nxt;
      ovf_r  <= ovf_nxt;
      busy_r <= busy_nxt;
      feed_r <= feed_nxt;
      frow_r <= frow_nxt;
    end
  end

  // row sums enter cell 0 at zero
  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = feed_r;
    chain[0].last   = feed_last;
    chain[0].row    = frow_r;
  end

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    always_comb begin
      mwr[g].we  = acc_in && (in_func == FN_MAT) && !oob && (in_col == IDX_W'(g));
      mwr[g].row = in_row;
      mwr[g].re  = in_value_re;
      mwr[g].im  = in_value_im;
    end
    assign vec_we[g] = acc_in && (in_func == FN_VEC) && (vcnt_r == CNT_W'(g));

    cmvm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .col_en  (CNT_W'(g) < n_eff),
      .mwr     (mwr[g]),
      .vec_we  (vec_we[g]),
      .vec_re  (in_value_re),
      .vec_im  (in_value_im),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  assign tail = chain[MAX_DIM];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (err_load || (adv && tail.valid)) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (err_load) begin
      out_status_r <= err_code;
      out_re_r     <= '0;
      out_im_r     <= '0;
      out_last_r   <= 1'b1;
    end else if (adv && tail.valid) begin
      out_status_r <= ST_OK;
      out_re_r     <= tail.acc_re;
      out_im_r     <= tail.acc_im;
      out_last_r   <= tail.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_re       = out_re_r;
  assign out_im       = out_im_r;
  assign out_last_out = out_last_r;

`ifndef ASSERT_OFF
  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> busy_r)
    else $error("row sum left the chain outside a computation");

  a_feed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    feed_r |-> busy_r)
    else $error("rows fed while not busy");

  a_err_vs_tail: assert property (@(posedge clk) disable iff (!rst_n)
    err_load |-> !tail.valid && !start)
    else $error("error word collides with chain output");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r && out_last_r && (out_status_r == ST_OK))
    else $error("computation ended without final row word");
`endif

endmodule : complex_matrix_vector_multiply
`default_nettype wire
